// File: hw/rtl/dria_pkg.sv
// ----------------------------------------------------------------------------
// dria_pkg
// Shared types and codes of the double range id allocator.
// ----------------------------------------------------------------------------
package dria_pkg;

    localparam int NUMBER_WIDTH_DEFAULT = 32;
    localparam int RANGE_WIDTH          = 32;
    localparam int OUT_NUMBER_WIDTH     = 31;
    localparam int S_TDATA_WIDTH        = 64;
    localparam int M_TDATA_WIDTH        = 40;

    typedef enum logic [0:0] {
        CMD_ADD = 1'b0,
        CMD_GET = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_RANGE  = 3'd1,
        ST_BOTH_FULL  = 3'd2,
        ST_NO_CURRENT = 3'd3,
        ST_EXHAUSTED  = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [RANGE_WIDTH-1:0] range_start;
        logic [RANGE_WIDTH-1:0] range_end;
    } item_t;

    // Packed with the number in the lowest bits, matching m_tdata.
    typedef struct packed {
        logic [3:0]                  pad;
        logic                        ready_res;
        logic                        refill_request;
        status_t                     status;
        logic [OUT_NUMBER_WIDTH-1:0] number;
    } result_t;

endpackage

// File: hw/rtl/dria_in_reg.sv
// ----------------------------------------------------------------------------
// dria_in_reg
// Input register: captures one request beat and holds it until the core
// can hand its result to the output register.
// ----------------------------------------------------------------------------
module dria_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dria_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output dria_pkg::item_t item
);
    import dria_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/dria_core.sv
// ----------------------------------------------------------------------------
// dria_core
// Range slots, current pointer and next number, with the add and get logic
// that updates them for one request beat.
// ----------------------------------------------------------------------------
module dria_core #(
    parameter int NUMBER_WIDTH = dria_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  dria_pkg::item_t    item,
    output dria_pkg::result_t  result
);
    import dria_pkg::*;

    // Range fields contribute at most 32 bits to a number.
    localparam int W  = (NUMBER_WIDTH > RANGE_WIDTH) ? RANGE_WIDTH : NUMBER_WIDTH;
    localparam int NW = NUMBER_WIDTH;

    logic [NW-1:0] slot_low_reg  [2];
    logic [NW-1:0] slot_high_reg [2];
    logic [NW-1:0] slot_low_next [2];
    logic [NW-1:0] slot_high_next[2];
    logic          have_current_reg, have_current_next;
    logic          current_slot_reg, current_slot_next;
    logic [NW-1:0] next_value_reg,   next_value_next;

    logic [W-1:0]  lo_w, hi_w;
    logic          range_ok;
    logic          full0, full1;
    logic [NW-1:0] cur_high, other_low;
    logic          other_full;
    logic          exhausted;
    logic [NW-1:0] base;
    logic [NW-1:0] number_full;
    status_t       status;
    logic          refill;

    assign lo_w = item.range_start[W-1:0];
    assign hi_w = item.range_end[W-1:0];

    // Both ends positive and the end above the start.
    assign range_ok = !lo_w[W-1] && (|lo_w) && !hi_w[W-1] && (|hi_w)
                      && (hi_w[W-2:0] > lo_w[W-2:0]);

    assign full0 = (|slot_low_reg[0]) || (|slot_high_reg[0]);
    assign full1 = (|slot_low_reg[1]) || (|slot_high_reg[1]);

    assign cur_high   = current_slot_reg ? slot_high_reg[1] : slot_high_reg[0];
    assign other_low  = current_slot_reg ? slot_low_reg[0]  : slot_low_reg[1];
    assign other_full = current_slot_reg ? full0 : full1;
    // Stored numbers are never negative, so an unsigned compare suffices.
    assign exhausted  = next_value_reg >= cur_high;

    always_comb begin
        slot_low_next     = slot_low_reg;
        slot_high_next    = slot_high_reg;
        have_current_next = have_current_reg;
        current_slot_next = current_slot_reg;
        next_value_next   = next_value_reg;
        status            = ST_OK;
        refill            = 1'b0;
        number_full       = '0;
        base              = next_value_reg;

        if (item.cmd == CMD_ADD) begin
            if (!range_ok) begin
                status = ST_BAD_RANGE;
            end else if (full0 && full1) begin
                status = ST_BOTH_FULL;
            end else begin
                slot_low_next[full0]  = NW'(lo_w);
                slot_high_next[full0] = NW'(hi_w);
                if (!have_current_reg) begin
                    have_current_next = 1'b1;
                    current_slot_next = full0;
                    next_value_next   = NW'(lo_w);
                end
            end
        end else if (!have_current_reg) begin
            status = ST_NO_CURRENT;
        end else begin
            if (exhausted) begin
                slot_low_next[current_slot_reg]  = '0;
                slot_high_next[current_slot_reg] = '0;
                if (other_full) begin
                    current_slot_next = !current_slot_reg;
                    base              = other_low;
                    refill            = 1'b1;
                end else begin
                    status = ST_EXHAUSTED;
                end
            end
            if (status == ST_OK) begin
                number_full     = base;
                next_value_next = base + NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_low_reg[0]  <= '0;
            slot_low_reg[1]  <= '0;
            slot_high_reg[0] <= '0;
            slot_high_reg[1] <= '0;
            have_current_reg <= 1'b0;
            current_slot_reg <= 1'b0;
            next_value_reg   <= '0;
        end else if (fire) begin
            slot_low_reg     <= slot_low_next;
            slot_high_reg    <= slot_high_next;
            have_current_reg <= have_current_next;
            current_slot_reg <= current_slot_next;
            next_value_reg   <= next_value_next;
        end
    end

    always_comb begin
        result                = '0;
        result.status         = status;
        result.refill_request = refill;
        result.ready_res      = have_current_next
                                && ((|slot_low_next[0]) || (|slot_high_next[0]))
                                && ((|slot_low_next[1]) || (|slot_high_next[1]));
        result.number         = OUT_NUMBER_WIDTH'(number_full);
    end

endmodule

// File: hw/rtl/dria_out_reg.sv
// ----------------------------------------------------------------------------
// dria_out_reg
// Result register: holds one result beat until the downstream side takes it
// and tells the input stage when it may move on.
// ----------------------------------------------------------------------------
module dria_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  dria_pkg::result_t in_result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output dria_pkg::result_t m_result
);
    import dria_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            result_reg <= in_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// File: hw/rtl/double_range_id_allocator.sv
// A request beat moves from the input register through the core into the result register;
// while the result side is stalling, it waits in the input register.
// Throughput: one request beat per cycle while the result side is not stalling; the add/get
// update is a single compare, select and increment between the input and result registers.
// Reset (aresetn low, synchronous): both slots empty, no current range,
// next number zero, both stages empty.
// ----------------------------------------------------------------------------
// double_range_id_allocator
// Hands out unique numbers from two ping-pong ranges supplied by add beats.
// ----------------------------------------------------------------------------
module double_range_id_allocator #(
    parameter int NUMBER_WIDTH = dria_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // range_start [31:0], range_end [63:32]
    input  logic [dria_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // cmd: 0 add, 1 get
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // number [30:0], status [33:31], refill_request [34], ready_res [35], zeros [39:36]
    output logic [dria_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import dria_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t m_result;

    assign s_item.cmd         = cmd_t'(s_tuser);
    assign s_item.range_start = s_tdata[RANGE_WIDTH-1:0];
    assign s_item.range_end   = s_tdata[2*RANGE_WIDTH-1:RANGE_WIDTH];

    dria_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dria_core #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && advance),
        .item    (item),
        .result  (result)
    );

    dria_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_result (result),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = m_result;

endmodule

// File: hw/rtl/dria_checker.sv
// ----------------------------------------------------------------------------
// dria_checker
// Port-level checks of the double range id allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dria_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [dria_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import dria_pkg::*;

    result_t res;
    assign res = m_tdata;

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A slot switch only happens on a successful get.
    a_refill_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.refill_request |-> res.status == ST_OK)
        else $error("refill request with an error status");

    // Any error reports a zero number and no refill.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status != ST_OK |-> res.number == '0 && !res.refill_request)
        else $error("error result carries a number or refill");

    // Nothing comes out the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // The pipeline is two deep, so an empty output means room at the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

endmodule

bind double_range_id_allocator dria_checker u_dria_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/double_range_id_allocator_test.sv
// ============================================================================
// double_range_id_allocator_test
// Self-checking bench for the ping-pong id range allocator. Add and get beats
// are streamed in with random gaps and random result back-pressure. A
// scoreboard predicts every result beat from its own model of the two slots
// and compares it field by field.
// ============================================================================
`timescale 1ns / 1ps

module double_range_id_allocator_test;
    import dria_pkg::*;

    // Tracks the slots and the next id, and holds the result beats still owed.
    class allocation_tracker;
        longint  slot_first[2];
        longint  slot_limit[2];
        bit      range_active;
        bit      active_slot;
        longint  next_id;
        result_t owed_results[$];
        int      errors;

        function bit slot_used(bit s);
            return slot_first[s] != 0 || slot_limit[s] != 0;
        endfunction

        function void note_request(cmd_t cmd, logic [31:0] first, logic [31:0] limit);
            result_t r;
            longint  lo;
            longint  hi;
            bit      sel;
            bit      other;
            r = '0;
            r.status = ST_OK;
            if (cmd == CMD_ADD) begin
                lo = longint'($signed(first));
                hi = longint'($signed(limit));
                if (lo <= 0 || hi <= 0 || hi <= lo) begin
                    r.status = ST_BAD_RANGE;
                end else if (!slot_used(0) || !slot_used(1)) begin
                    sel = slot_used(0);
                    slot_first[sel] = lo;
                    slot_limit[sel] = hi;
                    if (!range_active) begin
                        range_active = 1'b1;
                        active_slot  = sel;
                        next_id      = lo;
                    end
                end else begin
                    r.status = ST_BOTH_FULL;
                end
            end else if (!range_active) begin
                r.status = ST_NO_CURRENT;
            end else begin
                // An exhausted slot is freed even when there is nothing to switch to.
                if (next_id >= slot_limit[active_slot]) begin
                    other = ~active_slot;
                    slot_first[active_slot] = 0;
                    slot_limit[active_slot] = 0;
                    if (slot_first[other] > 0 && slot_limit[other] > slot_first[other]) begin
                        active_slot      = other;
                        next_id          = slot_first[other];
                        r.refill_request = 1'b1;
                    end else begin
                        r.status = ST_EXHAUSTED;
                    end
                end
                if (r.status == ST_OK) begin
                    r.number = next_id[30:0];
                    next_id  = next_id + 1;
                end
            end
            r.ready_res = range_active && slot_used(0) && slot_used(1);
            owed_results.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch in %s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(logic [M_TDATA_WIDTH-1:0] data);
            result_t got;
            result_t want;
            got = data;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat %h arrived with nothing owed", data);
                return;
            end
            want = owed_results.pop_front();
            if (got.number !== want.number)
                flag("number", want.number, got.number);
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.refill_request !== want.refill_request)
                flag("refill_request", want.refill_request, got.refill_request);
            if (got.ready_res !== want.ready_res)
                flag("ready_res", want.ready_res, got.ready_res);
            if (got.pad !== want.pad)
                flag("padding", want.pad, got.pad);
        endfunction
    endclass

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata  = '0;
    logic                     s_tuser  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    allocation_tracker tracker = new();
    bit                sender_quiet   = 1'b0;
    bit                receiver_quiet = 1'b0;
    int                ready_hold     = 0;

    double_range_id_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Result side: check each beat, then hold tready low for a drawn number of cycles.
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else begin
            hold = ready_hold;
            if (m_tvalid && m_tready) begin
                tracker.check_result(m_tdata);
                hold = receiver_quiet ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0) begin
                m_tready   <= 1'b0;
                ready_hold <= hold - 1;
            end else begin
                m_tready   <= 1'b1;
                ready_hold <= 0;
            end
        end
    end

    task automatic send_request(cmd_t cmd, logic [31:0] first, logic [31:0] limit);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {limit, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_request(cmd, first, limit);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.owed_results.size() != 0);
    endtask

    initial begin
        int          pick;
        int          span;
        logic [31:0] first;
        logic [31:0] limit;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(CMD_GET, 32'd0, 32'd0);                  // nothing current yet
        send_request(CMD_ADD, 32'd0, 32'd5);                  // start not positive
        send_request(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF);  // most negative start
        send_request(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // empty range
        send_request(CMD_ADD, 32'd5, 32'hFFFF_FFFF);          // negative end
        send_request(CMD_ADD, 32'd7, 32'd3);                  // end below start
        send_request(CMD_ADD, 32'd1, 32'd3);
        send_request(CMD_ADD, 32'h7FFF_FFFD, 32'h7FFF_FFFF);
        send_request(CMD_ADD, 32'd3, 32'd4);                  // both slots taken
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_GET, 32'd0, 32'd0);                  // switch with refill
        send_request(CMD_GET, $urandom, $urandom);
        send_request(CMD_GET, 32'd0, 32'd0);                  // other slot empty
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_ADD, 32'd10, 32'd12);
        send_request(CMD_GET, 32'd0, 32'd0);                  // late switch
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_ADD, 32'd20, 32'd23);                // refills the current slot
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_GET, 32'd0, 32'd0);
        send_request(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();

        for (int n = 0; n < 1950; n++) begin
            if (n % 150 == 0) begin
                sender_quiet   = $urandom_range(0, 1);
                receiver_quiet = $urandom_range(0, 1);
                if ($urandom_range(0, 2) == 0)
                    drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_request(CMD_GET, $urandom, $urandom);
            end else if (pick < 85) begin
                // Short ranges so that slots run dry and switch often.
                span  = $urandom_range(1, 5);
                first = $urandom_range(1, 32'h7FFF_FFFF - span);
                limit = first + span;
                send_request(CMD_ADD, first, limit);
            end else if (pick < 90) begin
                limit = 32'h7FFF_FFFF - $urandom_range(0, 3);
                first = limit - $urandom_range(1, 4);
                send_request(CMD_ADD, first, limit);
            end else if (pick < 95) begin
                send_request(CMD_ADD, $urandom, $urandom);
            end else begin
                first = $urandom_range(1, 32'h7FFF_FFFF);
                limit = first - $urandom_range(0, 3);
                send_request(CMD_ADD, first, limit);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
            $display("double_range_id_allocator_test: done, clean");
        end else begin
            $display("double_range_id_allocator_test: done, errors");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("double_range_id_allocator_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dria_pkg.sv
hw/rtl/dria_in_reg.sv
hw/rtl/dria_core.sv
hw/rtl/dria_out_reg.sv
hw/rtl/double_range_id_allocator.sv
hw/rtl/dria_checker.sv
test/double_range_id_allocator_test.sv
